### hdl/bqf_pkg.sv
package bqf_pkg;

  // Coefficient fraction bits
  localparam int COEF_FRAC_BITS = 30;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int STATE_W  = 40;             // output history, 8 guard bits
  localparam int NUM_W    = 33;             // numerator magnitude
  localparam int DEN_W    = 33;             // 2 * (1 + alpha)
  localparam int REM_W    = DEN_W + 1;
  localparam int DIV_W    = NUM_W + COEF_FRAC_BITS;
  localparam int COEF_W   = COEF_FRAC_BITS + 5;
  localparam int CHUNK_W  = 16;
  localparam int NCHUNK   = 3;              // 48-bit sign-extended operand
  localparam int PROD_W   = COEF_W + CHUNK_W + 1;
  localparam int ACC_W    = PROD_W + CHUNK_W * (NCHUNK - 1) + 4;
  localparam int CNT_W    = $clog2(DIV_W + 1);

  localparam logic [SAMPLE_W+1:0] UNIT_Q30 = (SAMPLE_W + 2)'(1) << 30;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd2;

  localparam logic [1:0] MODE_RESET = 2'd0;
  localparam int MODE_BP_BIT = 1;
  localparam int MODE_HP_BIT = 0;

  // Term order of the accumulation
  localparam logic [2:0] TERM_B0 = 3'd0;
  localparam logic [2:0] TERM_B1 = 3'd1;
  localparam logic [2:0] TERM_B2 = 3'd2;
  localparam logic [2:0] TERM_A1 = 3'd3;
  localparam logic [2:0] TERM_A2 = 3'd4;

endpackage

### hdl/biquad_filter_lp_hp_bp.sv
// Direct form I biquad (low-pass, high-pass or band-pass by cfg register 0).
// Each beat in yields one beat out. The five coefficients are rebuilt from
// cos_omega and alpha_coeff for every sample by one shared restoring divider
// (one quotient bit per cycle, 63 bits for 30 fraction bits), then each term
// goes through one shared 35x17 multiplier, three partial products per term.
// Each term runs setup, divide, round and multiply states; in_stall is high
// from accept to result, and while a finished result still waits on
// out_stall. History (x1, x2, y1, y2) resets to zero; y is kept with 8 guard
// bits and the output is saturated to 32 bits.
// Configuration writes are taken at any time but must only be made while idle.
module biquad_filter_lp_hp_bp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bqf_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [bqf_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bqf_pkg::SAMPLE_W-1:0]  out_sample_out
);
  import bqf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_DIV, ST_ROUND, ST_MUL, ST_ACC, ST_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [1:0]                 mode_r;
  logic signed [SAMPLE_W-1:0] cos_r;
  logic [SAMPLE_W-2:0]        alpha_r;

  // history
  logic signed [SAMPLE_W-1:0] x0_r, x1_r, x2_r;
  logic signed [STATE_W-1:0]  y1_r, y2_r;

  // sequencer
  logic [2:0]       term_r;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       chunk_r;

  // divider
  logic [DIV_W-1:0] dq_r;
  logic [REM_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic signed [COEF_W-1:0] coef_r;

  // multiplier / accumulator
  logic signed [PROD_W-1:0] prod_r;
  logic [1:0]               sh_r;
  logic                     pv_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  // ---- numerator / denominator selection ----
  logic signed [SAMPLE_W+1:0] c_ext, a_ext, num;
  logic [NUM_W-1:0]           mag;
  logic [DEN_W-1:0]           a0, den_sel;

  always_comb begin
    c_ext   = (SAMPLE_W + 2)'(cos_r);
    a_ext   = signed'({3'b000, alpha_r});
    a0      = DEN_W'(UNIT_Q30) + DEN_W'(alpha_r);
    num     = '0;
    den_sel = a0;
    case (term_r)
      TERM_B0, TERM_B2: begin
        if (mode_r[MODE_BP_BIT]) begin
          num = (term_r == TERM_B0) ? a_ext : -a_ext;
        end else if (mode_r[MODE_HP_BIT]) begin
          num     = UNIT_Q30 + c_ext;
          den_sel = a0 << 1;
        end else begin
          num     = UNIT_Q30 - c_ext;
          den_sel = a0 << 1;
        end
      end
      TERM_B1: begin
        if (mode_r[MODE_BP_BIT]) begin
          num = '0;
        end else if (mode_r[MODE_HP_BIT]) begin
          num = -(UNIT_Q30 + c_ext);
        end else begin
          num = UNIT_Q30 - c_ext;
        end
      end
      TERM_A1: num = c_ext <<< 1;            // -a1 numerator
      TERM_A2: num = a_ext - UNIT_Q30;       // -a2 numerator
      default: num = '0;
    endcase
    mag = num[SAMPLE_W+1] ? NUM_W'(-num) : NUM_W'(num);
  end

  // ---- one restoring step ----
  logic [REM_W-1:0] rem_try;
  logic             ge;
  logic             rnd;
  logic [COEF_W-1:0] q_rnd;

  always_comb begin
    rem_try = {rem_r[REM_W-2:0], dq_r[DIV_W-1]};
    ge      = rem_try >= {1'b0, den_r};
    rnd     = {rem_r, 1'b0} >= {2'b00, den_r};
    q_rnd   = {1'b0, dq_r[COEF_W-2:0]} + COEF_W'(rnd);
  end

  // ---- multiplier operand ----
  logic signed [STATE_W-1:0]          opnd;
  logic [CHUNK_W*NCHUNK-1:0]          opnd_ext;
  logic signed [CHUNK_W:0]            chunk;

  always_comb begin
    case (term_r)
      TERM_B0: opnd = STATE_W'(x0_r);
      TERM_B1: opnd = STATE_W'(x1_r);
      TERM_B2: opnd = STATE_W'(x2_r);
      TERM_A1: opnd = y1_r;
      TERM_A2: opnd = y2_r;
      default: opnd = '0;
    endcase
    opnd_ext = (CHUNK_W * NCHUNK)'(opnd);
    case (chunk_r)
      2'd0:    chunk = signed'({1'b0, opnd_ext[CHUNK_W-1:0]});
      2'd1:    chunk = signed'({1'b0, opnd_ext[2*CHUNK_W-1:CHUNK_W]});
      default: chunk = signed'({opnd_ext[3*CHUNK_W-1], opnd_ext[3*CHUNK_W-1:2*CHUNK_W]});
    endcase
  end

  // ---- accumulate, scale and saturate ----
  logic signed [ACC_W-1:0]   prod_sh;
  logic signed [ACC_W-1:0]   acc_rnd, y_full;
  logic signed [STATE_W-1:0] y40;
  logic signed [SAMPLE_W-1:0] y32;
  logic                      fits40, fits32;

  always_comb begin
    prod_sh = ACC_W'(prod_r) <<< {sh_r, 4'b0000};
    acc_rnd = acc_r + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
    y_full  = acc_rnd >>> COEF_FRAC_BITS;
    fits40  = (y_full[ACC_W-1:STATE_W-1] == '0) || (y_full[ACC_W-1:STATE_W-1] == '1);
    if (fits40) begin
      y40 = y_full[STATE_W-1:0];
    end else begin
      y40 = y_full[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    end
    fits32 = (y40[STATE_W-1:SAMPLE_W-1] == '0) || (y40[STATE_W-1:SAMPLE_W-1] == '1);
    if (fits32) begin
      y32 = y40[SAMPLE_W-1:0];
    end else begin
      y32 = y40[STATE_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_RESET;
      cos_r       <= SAMPLE_W'(UNIT_Q30);
      alpha_r     <= '0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      term_r      <= TERM_B0;
      cnt_r       <= '0;
      chunk_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MODE:  mode_r  <= cfg_data[1:0];
          REG_COS:   cos_r   <= cfg_data;
          REG_ALPHA: alpha_r <= cfg_data[SAMPLE_W-2:0];
          default: ;
        endcase
      end

      // result register: load on finish, drop once taken
      if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      pv_r <= (state_r == ST_MUL);
      if (pv_r) begin
        acc_r <= acc_r + prod_sh;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            x0_r    <= in_sample_in;
            acc_r   <= '0;
            term_r  <= TERM_B0;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          dq_r    <= {mag, {COEF_FRAC_BITS{1'b0}}};
          rem_r   <= '0;
          den_r   <= den_sel;
          neg_r   <= num[SAMPLE_W+1];
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          dq_r  <= {dq_r[DIV_W-2:0], ge};
          rem_r <= ge ? rem_try - {1'b0, den_r} : rem_try;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_W - 1)) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          coef_r  <= neg_r ? -signed'(q_rnd) : signed'(q_rnd);
          chunk_r <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= coef_r * chunk;
          sh_r    <= chunk_r;
          chunk_r <= chunk_r + 2'd1;
          if (chunk_r == 2'(NCHUNK - 1)) begin
            if (term_r == TERM_A2) begin
              state_r <= ST_ACC;
            end else begin
              term_r  <= term_r + 3'd1;
              state_r <= ST_SETUP;
            end
          end
        end
        ST_ACC: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_sample_r <= y32;
            x2_r         <= x1_r;
            x1_r         <= x0_r;
            y2_r         <= y1_r;
            y1_r         <= y40;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < CNT_W'(DIV_W)))
    else $error("divider ran past its last step");

  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (term_r <= TERM_A2))
    else $error("term index out of range");

  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && state_r == ST_IDLE))
    else $error("result not presented after finish");

  a_no_mul_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pv_r)
    else $error("product pending while idle");
`endif

endmodule
